@@ src/lagged_feedback_comb_filter_unit_defines.svh @@
`ifndef LAGGED_FEEDBACK_COMB_FILTER_UNIT_DEFINES_SVH
`define LAGGED_FEEDBACK_COMB_FILTER_UNIT_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define LFCF_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define LFCF_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ src/lfcf_pkg.sv @@
`timescale 1ns / 1ps

package lfcf_pkg;

   // Register file geometry.
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_DELAY = 2'd0,
      CSR_GAIN  = 2'd1,
      CSR_MIX   = 2'd2
   } csr_index_type;

   // Register field widths and reset values.
   localparam int DELAY_BITS = 12;
   localparam int GAIN_BITS  = 15;
   localparam int MIX_BITS   = 16;

   localparam int DELAY_RESET = 169;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 15'd29491;
   localparam logic [MIX_BITS-1:0]  MIX_RESET  = 16'd16384;

   // Q0.15 gain and Q1.15 mix limits: gain is clamped to 0.99, mix to exactly one.
   localparam logic [GAIN_BITS-1:0] GAIN_MAX = 15'd32440;
   localparam logic [MIX_BITS-1:0]  MIX_ONE  = 16'd32768;

   // Rounding of Q.15 products: add one half, then floor.
   localparam int Q_SHIFT    = 15;
   localparam int ROUND_BIAS = 16384;

endpackage

@@ src/lfcf_ram.sv @@
`timescale 1ns / 1ps

// Single-port-write, single-port-read memory with a registered read.
// A read at the address being written in the same cycle returns the old data.
module lfcf_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/lagged_feedback_comb_filter_unit.sv @@
`timescale 1ns / 1ps

// Feedback comb filter with a lagged feedback path, for Q1.15 audio. Each
// sample transfer on the req_ channel yields exactly one mixed sample on the
// rsp_ channel, in order. The block sustains one sample per clock cycle when
// it is not held by either wait below; a sample passes the stage 1, 2 and 3
// registers and the result register before rsp_tvalid. The rate is set by the
// two delay-line memories, each written once and read once per cycle. When
// FEEDBACK_LAG is between 1 and 3, a sample is held at the input until the
// feedback value it needs has been written back; at the default lag of 128
// no such wait ever occurs. A stall on rsp_tready stops the whole pipeline. Both
// stores read as zero after reset without a clearing pass: an entry counts as
// written once the write position has passed it or has wrapped at least once.
// Configuration writes through the csr_ port take effect on the next sample;
// they are meant to be issued only while no sample is in flight.

`include "lagged_feedback_comb_filter_unit_defines.svh"

module lagged_feedback_comb_filter_unit #(
   parameter int LINE_DEPTH   = 4096,
   parameter int FEEDBACK_LAG = 128,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic clock,
   input  logic reset,

   // Input sample channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Bits from the lowest up: sample_in (SAMPLE_BITS), then zero padding.
   input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,

   // Result sample channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Bits from the lowest up: sample_out (SAMPLE_BITS), then zero padding.
   output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] rsp_tdata,

   // Configuration write port.
   input  logic                               csr_wen,
   input  logic [lfcf_pkg::CSR_ADDR_BITS-1:0] csr_index,
   input  logic [lfcf_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   import lfcf_pkg::*;

   localparam int SB = SAMPLE_BITS;
   localparam int TW = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int AW = $clog2(LINE_DEPTH);
   // Width for the wrapped index arithmetic: holds any delay and the depth.
   localparam int IW = ((AW > DELAY_BITS) ? AW : DELAY_BITS) + 1;
   // Product and sum widths of the arithmetic stages.
   localparam int FW = SB + 16;
   localparam int PW = SB + 17;
   localparam int MW = SB + 18;

   localparam logic [IW-1:0] DEPTH_W  = IW'(LINE_DEPTH);
   localparam logic [IW-1:0] LAG_W    = IW'(FEEDBACK_LAG % LINE_DEPTH);
   localparam logic [AW-1:0] LAST_POS = AW'(LINE_DEPTH - 1);
   localparam logic [AW-1:0] DELAY_RESET_MOD = AW'(DELAY_RESET % LINE_DEPTH);

   // Saturation bounds, sign-extended to the widest pre-saturation value.
   localparam logic signed [SB+2:0] SAT_HI = {4'b0000, {(SB-1){1'b1}}};
   localparam logic signed [SB+2:0] SAT_LO = {4'b1111, {(SB-1){1'b0}}};

   function automatic logic signed [SB-1:0] clamp_sample(input logic signed [SB+2:0] v);
      logic signed [SB-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[SB-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[SB-1:0];
      end else begin
         r = v[SB-1:0];
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers. Clamping and the delay wrap are resolved at
   // write time so the sample path sees ready-to-use values.
   // ------------------------------------------------------------------
   logic [AW-1:0]        delay_mod_ff, delay_mod_in;
   logic [GAIN_BITS-1:0] gain_ff, gain_in;
   logic [MIX_BITS-1:0]  mix_wet_ff, mix_wet_in;
   logic [MIX_BITS-1:0]  mix_dry_ff, mix_dry_in;
   logic [IW-1:0]        csr_delay_ext;
   logic [IW-1:0]        csr_delay_mod;
   logic [GAIN_BITS-1:0] csr_gain;
   logic [MIX_BITS-1:0]  csr_mix;

   always_comb begin
      csr_delay_ext = IW'(csr_wdata[DELAY_BITS-1:0]);
      csr_delay_mod = (csr_delay_ext >= DEPTH_W) ? (csr_delay_ext - DEPTH_W) : csr_delay_ext;
      csr_gain      = csr_wdata[GAIN_BITS-1:0];
      csr_mix       = csr_wdata[MIX_BITS-1:0];

      delay_mod_in = delay_mod_ff;
      gain_in      = gain_ff;
      mix_wet_in   = mix_wet_ff;
      mix_dry_in   = mix_dry_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_DELAY: begin
               delay_mod_in = csr_delay_mod[AW-1:0];
            end
            CSR_GAIN: begin
               gain_in = (csr_gain > GAIN_MAX) ? GAIN_MAX : csr_gain;
            end
            CSR_MIX: begin
               mix_wet_in = (csr_mix > MIX_ONE) ? MIX_ONE : csr_mix;
               mix_dry_in = MIX_ONE - mix_wet_in;
            end
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_mod_ff <= DELAY_RESET_MOD;
         gain_ff      <= GAIN_RESET;
         mix_wet_ff   <= MIX_RESET;
         mix_dry_ff   <= MIX_ONE - MIX_RESET;
      end else begin
         delay_mod_ff <= delay_mod_in;
         gain_ff      <= gain_in;
         mix_wet_ff   <= mix_wet_in;
         mix_dry_ff   <= mix_dry_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline registers.
   //   Stage 1: memory read data arrives; the line sum is formed and written.
   //   Stage 2: the three products are formed.
   //   Stage 3: rounding and saturation; the feedback value is written.
   //   Output:  the result register toward rsp_.
   // ------------------------------------------------------------------
   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic [AW-1:0] pos_ff, pos_in;
   logic          wrapped_ff, wrapped_in;

   logic [AW-1:0]        s1_pos_ff;
   logic signed [SB-1:0] s1_x_ff;
   logic [AW-1:0]        s1_fb_addr_ff;
   logic                 s1_line_fwd_ff;
   logic                 s1_line_ok_ff;
   logic                 s1_fb_ok_ff;
   logic                 s1_zero_delay_ff;

   logic [AW-1:0]        s2_pos_ff;
   logic signed [SB-1:0] s2_x_ff;
   logic signed [SB-1:0] s2_wet_ff, s2_wet_in;

   logic [AW-1:0]        s3_pos_ff;
   logic signed [FW-1:0] s3_prod_fb_ff, s3_prod_fb_in;
   logic signed [PW-1:0] s3_prod_dry_ff, s3_prod_dry_in;
   logic signed [PW-1:0] s3_prod_wet_ff, s3_prod_wet_in;

   logic signed [SB-1:0] out_sample_ff, out_sample_in;
   logic signed [SB-1:0] last_sum_ff;

   // ------------------------------------------------------------------
   // Input side: read addresses, fill tracking and the feedback hazard.
   // ------------------------------------------------------------------
   logic          advance;
   logic          accept;
   logic          fb_hazard;
   logic [IW-1:0] pos_ext;
   logic [IW-1:0] delay_ext;
   logic [IW-1:0] line_back;
   logic [IW-1:0] fb_back;
   logic [AW-1:0] line_rd_addr;
   logic [AW-1:0] fb_rd_addr;
   logic          line_ok_in;
   logic          fb_ok_in;
   logic          line_fwd_in;

   // The pipeline moves whenever the result register is free or being drained.
   assign advance = !out_valid_ff || rsp_tready;

   always_comb begin
      pos_ext   = IW'(pos_ff);
      delay_ext = IW'(delay_mod_ff);
      line_back = (pos_ext >= delay_ext) ? (pos_ext - delay_ext)
                                         : (pos_ext + DEPTH_W - delay_ext);
      fb_back   = (pos_ext >= LAG_W) ? (pos_ext - LAG_W) : (pos_ext + DEPTH_W - LAG_W);
      line_rd_addr = line_back[AW-1:0];
      fb_rd_addr   = fb_back[AW-1:0];

      // Entries ahead of the write position are unwritten until the first wrap.
      line_ok_in = wrapped_ff || (line_rd_addr < pos_ff);
      fb_ok_in   = wrapped_ff || (fb_rd_addr < pos_ff);

      // The previous sample writes its line sum at the very edge this read
      // happens, so the read returns stale data and the sum is forwarded.
      line_fwd_in = s1_valid_ff && (s1_pos_ff == line_rd_addr);

      // A feedback value that is still in flight cannot be read yet.
      fb_hazard = (s1_valid_ff && (s1_pos_ff == fb_rd_addr))
               || (s2_valid_ff && (s2_pos_ff == fb_rd_addr))
               || (s3_valid_ff && (s3_pos_ff == fb_rd_addr));
   end

   assign req_tready = advance && !fb_hazard;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      if (accept) begin
         pos_in     = (pos_ff == LAST_POS) ? '0 : (pos_ff + 1'b1);
         wrapped_in = wrapped_ff || (pos_ff == LAST_POS);
      end
   end

   // ------------------------------------------------------------------
   // Delay line and feedback store.
   // ------------------------------------------------------------------
   logic signed [SB-1:0] line_sum;
   logic [SB-1:0]        line_rd_data;
   logic [SB-1:0]        fb_rd_data;
   logic signed [SB-1:0] fb_value;

   lfcf_ram #(
      .DEPTH (LINE_DEPTH),
      .WIDTH (SB)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (advance && s1_valid_ff),
      .wr_addr (s1_pos_ff),
      .wr_data (line_sum),
      .rd_en   (advance),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd_data)
   );

   lfcf_ram #(
      .DEPTH (LINE_DEPTH),
      .WIDTH (SB)
   ) u_feedback_ram (
      .clock   (clock),
      .wr_en   (advance && s3_valid_ff),
      .wr_addr (s3_pos_ff),
      .wr_data (fb_value),
      .rd_en   (advance),
      .rd_addr (fb_rd_addr),
      .rd_data (fb_rd_data)
   );

   // ------------------------------------------------------------------
   // Stage 1: add the lagged feedback to the dry sample and pick the wet tap.
   // ------------------------------------------------------------------
   logic signed [SB-1:0] fb_lagged;
   logic signed [SB:0]   sum_wide;

   always_comb begin
      fb_lagged = s1_fb_ok_ff ? $signed(fb_rd_data) : '0;
      sum_wide  = {s1_x_ff[SB-1], s1_x_ff} + {fb_lagged[SB-1], fb_lagged};
      line_sum  = clamp_sample({{2{sum_wide[SB]}}, sum_wide});

      // A zero delay taps the sum written by this very sample.
      if (s1_zero_delay_ff) begin
         s2_wet_in = line_sum;
      end else if (s1_line_fwd_ff) begin
         s2_wet_in = last_sum_ff;
      end else if (s1_line_ok_ff) begin
         s2_wet_in = $signed(line_rd_data);
      end else begin
         s2_wet_in = '0;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: feedback scaling and the dry/wet blend products.
   // ------------------------------------------------------------------
   always_comb begin
      s3_prod_fb_in  = s2_wet_ff * $signed({1'b0, gain_ff});
      s3_prod_dry_in = s2_x_ff * $signed({1'b0, mix_dry_ff});
      s3_prod_wet_in = s2_wet_ff * $signed({1'b0, mix_wet_ff});
   end

   // ------------------------------------------------------------------
   // Stage 3: round half up in Q.15, then saturate to the sample range.
   // ------------------------------------------------------------------
   logic signed [FW-1:0] fb_round;
   logic signed [FW-1:0] fb_shr;
   logic signed [MW-1:0] mix_round;
   logic signed [MW-1:0] mix_shr;

   always_comb begin
      fb_round  = s3_prod_fb_ff + FW'(ROUND_BIAS);
      fb_shr    = fb_round >>> Q_SHIFT;
      fb_value  = clamp_sample(fb_shr[SB+2:0]);

      mix_round = {s3_prod_dry_ff[PW-1], s3_prod_dry_ff}
                + {s3_prod_wet_ff[PW-1], s3_prod_wet_ff}
                + MW'(ROUND_BIAS);
      mix_shr   = mix_round >>> Q_SHIFT;
      out_sample_in = clamp_sample(mix_shr[SB+2:0]);
   end

   // ------------------------------------------------------------------
   // Control state: valid bits, write position and the wrap flag.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
         wrapped_ff   <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         wrapped_ff <= wrapped_in;
         if (advance) begin
            s1_valid_ff  <= accept;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   // Payload moves together with the valid bits.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pos_ff        <= pos_ff;
         s1_x_ff          <= $signed(req_tdata[SB-1:0]);
         s1_fb_addr_ff    <= fb_rd_addr;
         s1_line_fwd_ff   <= line_fwd_in;
         s1_line_ok_ff    <= line_ok_in;
         s1_fb_ok_ff      <= fb_ok_in;
         s1_zero_delay_ff <= (delay_mod_ff == '0);

         s2_pos_ff <= s1_pos_ff;
         s2_x_ff   <= s1_x_ff;
         s2_wet_ff <= s2_wet_in;

         s3_pos_ff      <= s2_pos_ff;
         s3_prod_fb_ff  <= s3_prod_fb_in;
         s3_prod_dry_ff <= s3_prod_dry_in;
         s3_prod_wet_ff <= s3_prod_wet_in;

         out_sample_ff <= out_sample_in;
      end
      // Keeps the sum written at the edge a following read may collide with.
      if (advance && s1_valid_ff) begin
         last_sum_ff <= line_sum;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = TW'($unsigned(out_sample_ff));

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   logic [AW-1:0] s2_pos_succ;

   assign s2_pos_succ = (s2_pos_ff == LAST_POS) ? '0 : (s2_pos_ff + 1'b1);

   // Stages 1 and 2, when both valid, carry consecutive write positions.
   `LFCF_ASSERT_NOW(a_pos_order, clock, reset, s1_valid_ff && s2_valid_ff, s1_pos_ff == s2_pos_succ, "stage positions out of order")

   // A forwarded line sum comes from the sample that just moved to stage 2.
   `LFCF_ASSERT_NEXT(a_line_fwd_src, clock, reset, accept && line_fwd_in, s1_valid_ff && s2_valid_ff, "line forward without a source")

   // The feedback entry a sample read was not still waiting in the pipeline.
   `LFCF_ASSERT_NOW(a_fb_hazard_free, clock, reset, s1_valid_ff, !(s2_valid_ff && (s2_pos_ff == s1_fb_addr_ff)) && !(s3_valid_ff && (s3_pos_ff == s1_fb_addr_ff)), "stale feedback read")

endmodule
